/* sv/nmt_pkg.sv */
// Package for the NMT slave heartbeat monitor: item types, codes, constants
// and the NMT command decode. No dependencies.
package nmt_pkg;

  localparam int unsigned TableEntriesDef = 32;
  localparam int unsigned MaxResults      = 32;
  localparam int unsigned ResCntW         = 6;
  localparam int unsigned CfgIdxW         = 1;
  localparam int unsigned CfgDataW        = 16;

  localparam logic [10:0] IdNmtCommand  = 11'h000;
  localparam logic [2:0]  IdHbFuncCode  = 3'b111;
  localparam logic [3:0]  LenCommand    = 4'd2;
  localparam logic [3:0]  LenHeartbeat  = 4'd1;
  localparam logic [15:0] SatMax        = 16'hFFFF;

  localparam logic [7:0] StInit    = 8'd0;
  localparam logic [7:0] StStopped = 8'd4;
  localparam logic [7:0] StOper    = 8'd5;
  localparam logic [7:0] StPreop   = 8'd127;

  localparam logic [7:0] CmdStart      = 8'h01;
  localparam logic [7:0] CmdStop       = 8'h02;
  localparam logic [7:0] CmdPreop      = 8'h80;
  localparam logic [7:0] CmdResetNode  = 8'h81;
  localparam logic [7:0] CmdResetComm  = 8'h82;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOwnNodeId = 1'b0,
    CfgTimeout   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FnFrame  = 2'd0,
    FnTick   = 2'd1,
    FnAdd    = 2'd2,
    FnRemove = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    EvNone     = 3'd0,
    EvOwnState = 3'd1,
    EvBootup   = 3'd2,
    EvNodeChg  = 3'd3,
    EvTimeout  = 3'd4,
    EvFull     = 3'd5,
    EvIgnored  = 3'd6
  } event_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [10:0] can_id;
    logic [3:0]  frame_length;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte1;
    logic [6:0]  node_addr;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [6:0]  event_node;
    logic [7:0]  prior_state;
    logic [7:0]  next_state;
    logic [15:0] timeout_total;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  node;
    logic [7:0]  state;
    logic        bootup_seen;
    logic        timed_out;
    logic [15:0] age;
    logic [15:0] timeouts;
  } entry_t;

  typedef struct packed {
    logic we;
    logic vset;
    logic vclr;
  } tbl_wr_t;

  function automatic logic [7:0] cmd_next(input logic [7:0] cmd, input logic [7:0] cur);
    logic [7:0] ns;
    ns = cur;
    case (cmd)
      CmdStart:     ns = StOper;
      CmdStop:      ns = StStopped;
      CmdPreop:     ns = StPreop;
      CmdResetNode: ns = StInit;
      CmdResetComm: ns = StInit;
      default:      ns = cur;
    endcase
    return ns;
  endfunction

endpackage

/* sv/nmt_table.sv */
// Node table of the heartbeat monitor: entry memory with registered read
// and one valid flop per entry. Depends on nmt_pkg.
module nmt_table import nmt_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef,
  parameter int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [IdxW-1:0]         rd_idx_i,
  output entry_t                  rd_data_o,
  input  tbl_wr_t                 wr_ctl_i,
  input  logic [IdxW-1:0]         wr_idx_i,
  input  entry_t                  wr_data_i,
  output logic [TableEntries-1:0] valid_o
);

  entry_t mem_q [TableEntries];
  entry_t rd_q;
  logic [TableEntries-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.we) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    rd_q <= mem_q[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_ctl_i.vset) begin
      valid_q[wr_idx_i] <= 1'b1;
    end else if (wr_ctl_i.vclr) begin
      valid_q[wr_idx_i] <= 1'b0;
    end
  end

  assign rd_data_o = rd_q;
  assign valid_o   = valid_q;

endmodule

/* sv/nmt_slave_heartbeat_monitor_unit.sv */
// NMT slave with heartbeat consumer: sequencer over a shared node table.
// Flow: a command or ignored frame goes straight to the flush state; a lookup (heartbeat,
// add, remove) walks the table in read and check states per entry until a hit or the last
// entry; a tick walks every entry in read and update states and holds on a stalled output.
// One item at a time: the next is accepted only once the sequencer is back in idle.
// Reset clears own state, table valid bits and config to their defaults; no sweep.
module nmt_slave_heartbeat_monitor_unit import nmt_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  // One-hot sequencer states
  typedef enum logic [5:0] {
    SIdle  = 6'b000001,
    SFRd   = 6'b000010,
    SFChk  = 6'b000100,
    STRd   = 6'b001000,
    STUpd  = 6'b010000,
    SFlush = 6'b100000
  } state_e;

  state_e state_q, state_d;
  in_item_t item_q, item_d;
  logic [6:0] key_q, key_d;
  logic [IdxW-1:0] idx_q, idx_d, free_idx_q, free_idx_d;
  logic free_v_q, free_v_d;
  logic [ResCntW-1:0] res_cnt_q, res_cnt_d;
  logic [6:0] own_id_q, own_id_d;
  logic [15:0] limit_q, limit_d;
  logic [7:0] own_st_q, own_st_d;
  out_item_t pend_q, pend_d, out_q, out_d;
  logic pend_v_q, pend_v_d, out_v_q, out_v_d;

  entry_t rd_data, wr_data;
  tbl_wr_t wr_ctl;
  logic [IdxW-1:0] wr_idx;
  logic [TableEntries-1:0] valid;

  nmt_table #(.TableEntries(TableEntries), .IdxW(IdxW)) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (idx_q),
    .rd_data_o (rd_data),
    .wr_ctl_i  (wr_ctl),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data),
    .valid_o   (valid)
  );

  assign in_ready_o  = (state_q == SIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  always_comb begin
    logic out_free, emit, hit, fv, last_e, tmo;
    logic [IdxW-1:0] fi;
    logic [15:0] age2, cnt2;
    logic [7:0] ns;
    out_item_t ev;
    entry_t nw;

    state_d = state_q; item_d = item_q; key_d = key_q; idx_d = idx_q;
    free_idx_d = free_idx_q; free_v_d = free_v_q; res_cnt_d = res_cnt_q;
    own_id_d = own_id_q; limit_d = limit_q; own_st_d = own_st_q;
    pend_d = pend_q; pend_v_d = pend_v_q; out_d = out_q; out_v_d = out_v_q;
    wr_ctl = '0; wr_idx = idx_q; wr_data = rd_data;
    emit = 1'b0; ev = '0; nw = rd_data; ns = own_st_q;
    age2 = '0; cnt2 = '0; tmo = 1'b0;

    out_free = !out_v_q || out_ready_i;
    if (out_v_q && out_ready_i) out_v_d = 1'b0;

    hit    = valid[idx_q] && (rd_data.node == key_q);
    fv     = free_v_q || !valid[idx_q];
    fi     = free_v_q ? free_idx_q : idx_q;
    last_e = (idx_q == LastIdx);

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgOwnNodeId: own_id_d = cfg_data_i[6:0];
        CfgTimeout:   limit_d  = cfg_data_i;
        default:      ;
      endcase
    end

    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          item_d = in_item_i; idx_d = '0; free_v_d = 1'b0; res_cnt_d = '0;
          key_d = in_item_i.node_addr;
          state_d = SFRd;
          case (in_item_i.func)
            FnFrame: begin
              key_d = in_item_i.can_id[6:0];
              ev.event_node = in_item_i.can_id[6:0];
              ev.event_res  = EvIgnored;
              if (in_item_i.can_id == IdNmtCommand && in_item_i.frame_length == LenCommand) begin
                state_d = SFlush;
                if (in_item_i.data_byte1 != 8'd0 && in_item_i.data_byte1 != {1'b0, own_id_q}) begin
                  emit = 1'b1;
                end else begin
                  ns = cmd_next(in_item_i.data_byte0, own_st_q);
                  if (ns != own_st_q) begin
                    emit = 1'b1;
                    ev.event_res = EvOwnState; ev.event_node = own_id_q;
                    ev.prior_state = own_st_q; ev.next_state = ns;
                    own_st_d = ns;
                  end
                end
              end else if (in_item_i.can_id[10:8] == IdHbFuncCode &&
                           in_item_i.frame_length == LenHeartbeat) begin
                // drop own heartbeat
                if (in_item_i.can_id[6:0] == own_id_q) begin
                  emit = 1'b1; state_d = SFlush;
                end
              end else begin
                emit = 1'b1; state_d = SFlush;
              end
            end
            FnTick:  state_d = STRd;
            default: state_d = SFRd;
          endcase
        end
      end
      SFRd: state_d = SFChk;
      SFChk: begin
        if (hit) begin
          state_d = SFlush;
          case (item_q.func)
            FnFrame: begin
              nw.state = item_q.data_byte0; nw.age = '0; nw.timed_out = 1'b0;
              ev.event_node = key_q; ev.next_state = item_q.data_byte0;
              if (item_q.data_byte0 == StInit && !rd_data.bootup_seen) begin
                nw.bootup_seen = 1'b1; emit = 1'b1; ev.event_res = EvBootup;
              end else if (rd_data.state != item_q.data_byte0) begin
                emit = 1'b1; ev.event_res = EvNodeChg; ev.prior_state = rd_data.state;
              end
              wr_ctl.we = 1'b1; wr_data = nw;
            end
            FnAdd: begin
              wr_ctl.we = 1'b1;
              wr_data = '{node: key_q, state: StInit, bootup_seen: 1'b0,
                          timed_out: 1'b0, age: '0, timeouts: '0};
            end
            default: wr_ctl.vclr = 1'b1;
          endcase
        end else if (last_e) begin
          state_d = SFlush;
          if (item_q.func != FnRemove) begin
            ev.event_node = key_q;
            if (fv) begin
              wr_idx = fi; wr_ctl.we = 1'b1; wr_ctl.vset = 1'b1;
              wr_data = '{node: key_q, state: StInit, bootup_seen: 1'b0,
                          timed_out: 1'b0, age: '0, timeouts: '0};
              if (item_q.func == FnFrame) begin
                wr_data.state = item_q.data_byte0;
                wr_data.bootup_seen = (item_q.data_byte0 == StInit);
                emit = 1'b1; ev.event_res = EvBootup; ev.next_state = item_q.data_byte0;
              end
            end else begin
              emit = 1'b1; ev.event_res = EvFull;
            end
          end
        end else begin
          idx_d = idx_q + 1'b1; free_v_d = fv; free_idx_d = fi; state_d = SFRd;
        end
      end
      STRd: state_d = STUpd;
      STUpd: begin
        age2 = (rd_data.age == SatMax) ? SatMax : rd_data.age + 16'd1;
        cnt2 = (rd_data.timeouts == SatMax) ? SatMax : rd_data.timeouts + 16'd1;
        tmo  = valid[idx_q] && (age2 > limit_q) && !rd_data.timed_out &&
               (res_cnt_q < ResCntW'(MaxResults));
        // hold while a second result has nowhere to go
        if (!(tmo && pend_v_q && !out_free)) begin
          if (valid[idx_q]) begin
            nw.age = age2;
            if (tmo) begin
              nw.timed_out = 1'b1; nw.timeouts = cnt2;
              emit = 1'b1; ev.event_res = EvTimeout; ev.event_node = rd_data.node;
              ev.next_state = rd_data.state; ev.timeout_total = cnt2;
              res_cnt_d = res_cnt_q + 1'b1;
            end
            wr_ctl.we = 1'b1; wr_data = nw;
          end
          if (last_e) begin
            state_d = SFlush;
          end else begin
            idx_d = idx_q + 1'b1; state_d = STRd;
          end
        end
      end
      SFlush: begin
        if (!pend_v_q) begin
          state_d = SIdle;
        end else if (out_free) begin
          out_d = pend_q; out_d.last = 1'b1; out_v_d = 1'b1;
          pend_v_d = 1'b0; state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase

    // advance the held result to the output when a newer one arrives
    if (emit) begin
      if (pend_v_q) begin
        out_d = pend_q; out_d.last = 1'b0; out_v_d = 1'b1;
      end
      pend_d = ev; pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      own_id_q <= 7'd1;
      limit_q  <= 16'd1000;
      own_st_q <= StInit;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      res_cnt_q <= '0;
      free_v_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      own_id_q <= own_id_d;
      limit_q  <= limit_d;
      own_st_q <= own_st_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      res_cnt_q <= res_cnt_d;
      free_v_q <= free_v_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    key_q      <= key_d;
    free_idx_q <= free_idx_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
  end

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for nmt_slave_heartbeat_monitor_unit: directed rows,
// then random phases under several register settings. Depends on nmt_pkg.
module tb_top;
  import nmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumEntries = 32;
  localparam int unsigned CycleLimit = 2000000;
  // Longest walk through the table plus margin, used before register writes.
  localparam int unsigned DrainCycles = 2 * NumEntries + 40;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_item_t            in_item_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  nmt_slave_heartbeat_monitor_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  // Mirror of the block: own state, registers and the node table.
  logic [6:0]  own_id;
  logic [15:0] hb_limit;
  logic [7:0]  own_st;
  logic        tbl_used  [NumEntries];
  logic [6:0]  tbl_node  [NumEntries];
  logic [7:0]  tbl_st    [NumEntries];
  logic        tbl_boot  [NumEntries];
  logic        tbl_late  [NumEntries];
  logic [15:0] tbl_age   [NumEntries];
  logic [15:0] tbl_cnt   [NumEntries];

  out_item_t events_due[$];   // results still owed by the block
  out_item_t item_events[$];  // results of the item just accepted
  int unsigned mismatches = 0;
  bit calm = 1'b0;            // no idling on either side while set
  int unsigned cycles = 0;

  function automatic void add_event(event_e ev, logic [6:0] node, logic [7:0] olds,
                                    logic [7:0] news, logic [15:0] tot);
    out_item_t r;
    if (item_events.size() >= MaxResults) return;
    r.event_res = ev;
    r.event_node = node;
    r.prior_state = olds;
    r.next_state = news;
    r.timeout_total = tot;
    r.last = 1'b0;
    item_events.push_back(r);
  endfunction

  function automatic int find_node(logic [6:0] node);
    for (int i = 0; i < NumEntries; i++)
      if (tbl_used[i] && tbl_node[i] == node) return i;
    return -1;
  endfunction

  function automatic int claim_entry(logic [6:0] node, logic [7:0] st);
    for (int i = 0; i < NumEntries; i++) begin
      if (!tbl_used[i]) begin
        tbl_used[i] = 1'b1;
        tbl_node[i] = node;
        tbl_st[i] = st;
        tbl_boot[i] = 1'b0;
        tbl_late[i] = 1'b0;
        tbl_age[i] = '0;
        tbl_cnt[i] = '0;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void apply_heartbeat(logic [6:0] node, logic [7:0] st);
    int e;
    logic [7:0] prev;
    e = find_node(node);
    if (e < 0) begin
      e = claim_entry(node, st);
      if (e < 0) begin
        add_event(EvFull, node, '0, '0, '0);
        return;
      end
      tbl_boot[e] = (st == StInit);
      add_event(EvBootup, node, '0, st, '0);
      return;
    end
    prev = tbl_st[e];
    tbl_st[e] = st;
    tbl_age[e] = '0;
    tbl_late[e] = 1'b0;
    if (st == StInit && !tbl_boot[e]) begin
      tbl_boot[e] = 1'b1;
      add_event(EvBootup, node, '0, st, '0);
    end else if (prev != st) begin
      add_event(EvNodeChg, node, prev, st, '0);
    end
  endfunction

  // Work out the results of one accepted item and queue them.
  function automatic void predict_events(in_item_t it);
    logic [6:0] low;
    logic [7:0] ns;
    int e;
    item_events.delete();
    low = it.can_id[6:0];
    case (func_e'(it.func))
      FnFrame: begin
        if (it.can_id == IdNmtCommand && it.frame_length == LenCommand) begin
          if (it.data_byte1 != 8'd0 && it.data_byte1 != {1'b0, own_id}) begin
            add_event(EvIgnored, low, '0, '0, '0);
          end else begin
            ns = own_st;
            case (it.data_byte0)
              CmdStart: ns = StOper;
              CmdStop: ns = StStopped;
              CmdPreop: ns = StPreop;
              CmdResetNode, CmdResetComm: ns = StInit;
              default: ns = own_st;
            endcase
            if (ns != own_st) begin
              add_event(EvOwnState, own_id, own_st, ns, '0);
              own_st = ns;
            end
          end
        end else if (it.can_id[10:8] == IdHbFuncCode && it.frame_length == LenHeartbeat) begin
          if (low == own_id) add_event(EvIgnored, low, '0, '0, '0);
          else apply_heartbeat(low, it.data_byte0);
        end else begin
          add_event(EvIgnored, low, '0, '0, '0);
        end
      end
      FnTick: begin
        for (int i = 0; i < NumEntries; i++) begin
          if (!tbl_used[i]) continue;
          if (tbl_age[i] != SatMax) tbl_age[i]++;
          if (tbl_age[i] > hb_limit && !tbl_late[i] && item_events.size() < MaxResults) begin
            tbl_late[i] = 1'b1;
            if (tbl_cnt[i] != SatMax) tbl_cnt[i]++;
            add_event(EvTimeout, tbl_node[i], '0, tbl_st[i], tbl_cnt[i]);
          end
        end
      end
      FnAdd: begin
        e = find_node(it.node_addr);
        if (e >= 0) begin
          tbl_st[e] = StInit;
          tbl_boot[e] = 1'b0;
          tbl_late[e] = 1'b0;
          tbl_age[e] = '0;
          tbl_cnt[e] = '0;
        end else if (claim_entry(it.node_addr, StInit) < 0) begin
          add_event(EvFull, it.node_addr, '0, '0, '0);
        end
      end
      default: begin
        e = find_node(it.node_addr);
        if (e >= 0) tbl_used[e] = 1'b0;
      end
    endcase
    if (item_events.size() > 0) item_events[item_events.size() - 1].last = 1'b1;
    foreach (item_events[k]) events_due.push_back(item_events[k]);
  endfunction

  function automatic int pick_gap();
    if (calm || $urandom_range(99) >= 14) return 0;
    return $urandom_range(1, 8);
  endfunction

  // Present one item, hold it until accepted, then predict.
  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_events(it);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write one register; the block is idle when this is called.
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CfgOwnNodeId) own_id = val[6:0];
    else hb_limit = val;
    @(posedge clk_i);
  endtask

  function automatic in_item_t frame(logic [10:0] id, logic [3:0] len, logic [7:0] b0,
                                     logic [7:0] b1);
    in_item_t it;
    it = '0;
    it.func = FnFrame;
    it.can_id = id;
    it.frame_length = len;
    it.data_byte0 = b0;
    it.data_byte1 = b1;
    return it;
  endfunction

  function automatic in_item_t node_op(func_e fn, logic [6:0] node);
    in_item_t it;
    it = '0;
    it.func = fn;
    it.node_addr = node;
    return it;
  endfunction

  function automatic out_item_t one_event(event_e ev, logic [6:0] node, logic [7:0] olds,
                                          logic [7:0] news);
    out_item_t r;
    r = '0;
    r.event_res = ev;
    r.event_node = node;
    r.prior_state = olds;
    r.next_state = news;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] pick_state();
    case ($urandom_range(4))
      0: return StInit;
      1: return StStopped;
      2: return StOper;
      3: return StPreop;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed traffic over a pool of nodes; the rest is noise.
  function automatic in_item_t random_item(int pool);
    in_item_t it;
    logic [63:0] noise;
    logic [6:0] node;
    int pick;
    noise = {$urandom, $urandom};
    it = noise[$bits(in_item_t)-1:0];
    node = 7'($urandom_range(2, 1 + pool));
    if ($urandom_range(9) == 0) node = 7'($urandom_range(127));
    pick = $urandom_range(99);
    if (pick < 35) begin
      it.func = FnFrame;
      it.can_id = {IdHbFuncCode, 1'($urandom_range(1)), node};
      it.frame_length = LenHeartbeat;
      it.data_byte0 = pick_state();
    end else if (pick < 60) begin
      it.func = FnTick;
    end else if (pick < 70) begin
      it.func = FnAdd;
      it.node_addr = node;
    end else if (pick < 78) begin
      it.func = FnRemove;
      it.node_addr = node;
    end else if (pick < 88) begin
      it.func = FnFrame;
      it.can_id = IdNmtCommand;
      it.frame_length = LenCommand;
      case ($urandom_range(6))
        0: it.data_byte0 = CmdStart;
        1: it.data_byte0 = CmdStop;
        2: it.data_byte0 = CmdPreop;
        3: it.data_byte0 = CmdResetNode;
        4: it.data_byte0 = CmdResetComm;
        default: it.data_byte0 = 8'($urandom_range(255));
      endcase
      case ($urandom_range(3))
        0: it.data_byte1 = 8'd0;
        1: it.data_byte1 = {1'b0, own_id};
        default: it.data_byte1 = 8'($urandom_range(255));
      endcase
    end else begin
      it.func = FnFrame;  // random frame: mostly ignored
    end
    return it;
  endfunction

  typedef struct {
    in_item_t  it;
    bit        known;
    out_item_t want;
  } row_t;

  row_t rows[$];

  // Check each result against the oldest owed result; stall at random.
  always @(posedge clk_i) begin
    out_item_t want;
    out_ready_i <= calm || ($urandom_range(99) >= 14);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (events_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item_o);
      end else begin
        want = events_due.pop_front();
        if (out_item_o.event_res != want.event_res ||
            out_item_o.event_node != want.event_node ||
            out_item_o.prior_state != want.prior_state ||
            out_item_o.next_state != want.next_state ||
            out_item_o.timeout_total != want.timeout_total ||
            out_item_o.last != want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, out_item_o);
        end
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int pool;
    int count;
    own_id = 7'd1;
    hb_limit = 16'd1000;
    own_st = StInit;
    foreach (tbl_used[i]) tbl_used[i] = 1'b0;

    // Directed rows, starting from the reset settings.
    rows.push_back('{frame(11'h000, 4'd2, CmdStart, 8'd0), 1'b1,
                     one_event(EvOwnState, 7'd1, 8'd0, 8'd5)});
    rows.push_back('{frame(11'h000, 4'd2, CmdStop, 8'd1), 1'b1,
                     one_event(EvOwnState, 7'd1, 8'd5, 8'd4)});
    rows.push_back('{frame(11'h000, 4'd2, CmdPreop, 8'd2), 1'b1,
                     one_event(EvIgnored, 7'd0, 8'd0, 8'd0)});
    rows.push_back('{frame(11'h000, 4'd2, 8'h55, 8'd0), 1'b0, '0});
    rows.push_back('{frame(11'h000, 4'd2, CmdPreop, 8'd0), 1'b1,
                     one_event(EvOwnState, 7'd1, 8'd4, 8'd127)});
    rows.push_back('{frame(11'h000, 4'd2, CmdResetNode, 8'd0), 1'b1,
                     one_event(EvOwnState, 7'd1, 8'd127, 8'd0)});
    rows.push_back('{frame(11'h000, 4'd2, CmdResetComm, 8'd0), 1'b0, '0});
    rows.push_back('{frame(11'h7FF, 4'd8, 8'hFF, 8'hFF), 1'b1,
                     one_event(EvIgnored, 7'h7F, 8'd0, 8'd0)});
    rows.push_back('{frame(11'h000, 4'd15, 8'h00, 8'h00), 1'b1,
                     one_event(EvIgnored, 7'd0, 8'd0, 8'd0)});
    rows.push_back('{frame(11'h701, 4'd1, 8'd5, 8'd0), 1'b1,
                     one_event(EvIgnored, 7'd1, 8'd0, 8'd0)});
    rows.push_back('{frame(11'h705, 4'd1, 8'd0, 8'd0), 1'b1,
                     one_event(EvBootup, 7'd5, 8'd0, 8'd0)});
    rows.push_back('{frame(11'h705, 4'd1, 8'd0, 8'd0), 1'b0, '0});
    rows.push_back('{frame(11'h705, 4'd1, 8'd5, 8'd0), 1'b0, '0});
    rows.push_back('{frame(11'h785, 4'd1, 8'd0, 8'd0), 1'b0, '0});
    rows.push_back('{frame(11'h7FF, 4'd1, 8'hFF, 8'd0), 1'b1,
                     one_event(EvBootup, 7'h7F, 8'd0, 8'd255)});
    rows.push_back('{frame(11'h706, 4'd1, 8'd127, 8'd0), 1'b1,
                     one_event(EvBootup, 7'd6, 8'd0, 8'd127)});
    rows.push_back('{frame(11'h706, 4'd1, 8'd0, 8'd0), 1'b0, '0});
    rows.push_back('{frame(11'h706, 4'd1, 8'd0, 8'd0), 1'b0, '0});
    rows.push_back('{node_op(FnAdd, 7'd9), 1'b0, '0});
    rows.push_back('{node_op(FnAdd, 7'd9), 1'b0, '0});
    rows.push_back('{node_op(FnRemove, 7'd9), 1'b0, '0});
    rows.push_back('{node_op(FnRemove, 7'd100), 1'b0, '0});
    rows.push_back('{node_op(FnAdd, 7'd0), 1'b0, '0});
    rows.push_back('{node_op(FnTick, 7'd0), 1'b0, '0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      send_item(rows[r].it);
      if (rows[r].known && !(item_events.size() == 1 && item_events[0] == rows[r].want)) begin
        mismatches++;
        if (mismatches <= 10) $display("row %0d: predicted result differs from table", r);
      end
    end

    // Random phases under different settings; each phase writes both registers.
    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      case (ph)
        0: begin write_reg(CfgOwnNodeId, 16'd127); write_reg(CfgTimeout, 16'd0); end
        1: begin write_reg(CfgOwnNodeId, 16'd1); write_reg(CfgTimeout, 16'hFFFF); end
        2: begin write_reg(CfgOwnNodeId, 16'(4)); write_reg(CfgTimeout, 16'd3); end
        default: begin
          write_reg(CfgOwnNodeId, 16'($urandom_range(1, 127)));
          write_reg(CfgTimeout, 16'($urandom_range(0, 12)));
        end
      endcase
      pool = (ph == 3) ? 45 : ((ph == 0) ? 40 : 10);
      count = 90;
      for (int n = 0; n < count; n++) begin
        calm = (ph == 2 && n >= 20 && n < 60);
        if (ph == 1 && n == 45) begin
          // Hold off until every owed result is out.
          in_valid_i <= 1'b0;
          while (events_due.size() != 0) @(posedge clk_i);
          @(posedge clk_i);
        end
        send_item(random_item(pool));
      end
      calm = 1'b0;
    end

    in_valid_i <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && events_due.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
